>>> rtl/core/trna_pkg.sv
// shared types and constants for the tree rank neighbour / ancestor pipeline
package trna_pkg;

  localparam int MAX_LEVELS = 4;
  localparam int RANK_BITS  = 16;

  localparam int NUM_LEVELS = 4;
  localparam int LVL_W      = $clog2(NUM_LEVELS);
  localparam int CNT_W      = $clog2(NUM_LEVELS + 1);
  localparam int BR_W       = 8;
  localparam int SIZE_W     = 16;
  localparam int RANK_W     = 16;
  localparam int OPD_W      = 16;
  localparam int DEPTH_W    = 3;
  localparam int START_W    = SIZE_W + LVL_W;
  localparam int WT_W       = BR_W * (NUM_LEVELS - 1);
  localparam int PROD_W     = BR_W + WT_W;
  localparam int ID_W       = PROD_W + LVL_W + 1;
  localparam int CFG_IDX_W  = $clog2(2 * NUM_LEVELS);
  localparam int CFG_DATA_W = SIZE_W;

  localparam logic [ID_W-1:0] RANK_MAX = (ID_W)'((64'd1 << RANK_BITS) - 64'd1);

  typedef enum logic {
    CMD_NEIGHBOUR = 1'b0,
    CMD_ANCESTOR  = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BRANCHING_0 = 3'd0,
    CFG_BRANCHING_1 = 3'd1,
    CFG_BRANCHING_2 = 3'd2,
    CFG_BRANCHING_3 = 3'd3,
    CFG_LVL_SIZE_0  = 3'd4,
    CFG_LVL_SIZE_1  = 3'd5,
    CFG_LVL_SIZE_2  = 3'd6,
    CFG_LVL_SIZE_3  = 3'd7
  } cfg_reg_t;

  typedef logic [NUM_LEVELS-1:0][BR_W-1:0]   br_arr_t;
  typedef logic [NUM_LEVELS-1:0][SIZE_W-1:0] size_arr_t;

  // one beat as it travels down the chain of level cells
  typedef struct packed {
    logic                                nbr;
    logic                                ovr;
    logic [RANK_W-1:0]                   ovr_rank;
    logic                                bad;
    logic [CNT_W-1:0]                    cnt;
    logic [OPD_W-1:0]                    rem;
    logic [ID_W-1:0]                     id;
    logic [WT_W-1:0]                     wt;
    logic [PROD_W-1:0]                   prod;
    logic [START_W-1:0]                  start;
    logic [NUM_LEVELS-1:0][BR_W-1:0]     path;
    logic [NUM_LEVELS-1:0][LVL_W-1:0]    lvl;
  } beat_t;

endpackage

>>> rtl/core/trna_prep.sv
// front stage: depth clamp, special cases, level start select and digit reorder
module trna_prep import trna_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  output logic                in_rdy,
  input  logic                cmd,
  input  logic [RANK_W-1:0]   node_rank,
  input  logic [DEPTH_W-1:0]  node_depth,
  input  br_arr_t             path_in,
  input  logic [OPD_W-1:0]    operand,
  input  size_arr_t           lvl_size,
  output logic                out_vld,
  output beat_t               out_beat,
  input  logic                out_rdy
);

  logic                              vld_r, vld_nxt;
  beat_t                             beat_r, beat_nxt;
  logic [CNT_W-1:0]                  depth_c;
  logic [NUM_LEVELS:0][START_W-1:0]  starts;
  logic [CNT_W-1:0]                  idx;

  assign in_rdy = !vld_r || out_rdy;

  always_comb begin
    depth_c = (node_depth > DEPTH_W'(MAX_LEVELS)) ? CNT_W'(MAX_LEVELS) : CNT_W'(node_depth);

    starts[0] = '0;
    for (int k = 0; k < NUM_LEVELS; k++) begin
      starts[k+1] = starts[k] + START_W'(lvl_size[k]);
    end

    beat_nxt          = '0;
    beat_nxt.nbr      = (cmd == CMD_NEIGHBOUR);
    beat_nxt.rem      = operand;
    beat_nxt.wt       = WT_W'(1);
    if (cmd == CMD_NEIGHBOUR) begin
      beat_nxt.cnt = depth_c;
    end else if (node_rank == '0) begin
      beat_nxt.ovr = 1'b1;
    end else if (operand == OPD_W'(depth_c)) begin
      beat_nxt.ovr      = 1'b1;
      beat_nxt.ovr_rank = node_rank;
    end else if (operand > OPD_W'(depth_c)) begin
      beat_nxt.ovr = 1'b1;
      beat_nxt.bad = 1'b1;
    end else begin
      beat_nxt.cnt = CNT_W'(operand);
    end
    beat_nxt.start = starts[beat_nxt.cnt];

    // cell j works on level cnt-1-j, deepest first
    idx = '0;
    for (int j = 0; j < NUM_LEVELS; j++) begin
      idx              = beat_nxt.cnt - CNT_W'(j) - CNT_W'(1);
      beat_nxt.lvl[j]  = idx[LVL_W-1:0];
      beat_nxt.path[j] = path_in[idx[LVL_W-1:0]];
    end

    vld_nxt = in_rdy ? in_vld : vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) begin
      beat_r <= beat_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_beat = beat_r;

endmodule

>>> rtl/core/trna_cell.sv
// one level cell: mixed-radix digit extraction, digit add and weighted accumulate
module trna_cell import trna_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  br_arr_t  branching,
  input  logic     in_vld,
  input  beat_t    in_beat,
  output logic     in_rdy,
  output logic     out_vld,
  output beat_t    out_beat,
  input  logic     out_rdy
);

  typedef struct packed {
    beat_t            bt;
    logic [BR_W-1:0]  base;
    logic [BR_W-1:0]  part;
    logic [BR_W-1:0]  pmod;
  } cell_stage_t;

  // restoring division over one byte of dividend bits, returns {remainder, quotient}
  function automatic logic [2*BR_W-1:0] div_steps(input logic [BR_W-1:0] rem_i,
                                                  input logic [BR_W-1:0] bits,
                                                  input logic [BR_W-1:0] base);
    logic [BR_W:0]   t;
    logic [BR_W-1:0] rem;
    logic [BR_W-1:0] q;
    rem = rem_i;
    q   = '0;
    for (int i = BR_W - 1; i >= 0; i--) begin
      t = {rem, bits[i]};
      if (t >= {1'b0, base}) begin
        t    = t - {1'b0, base};
        q[i] = 1'b1;
      end
      rem = t[BR_W-1:0];
    end
    return {rem, q};
  endfunction

  logic                  a_vld_r, a_vld_nxt, b_vld_r, b_vld_nxt, c_vld_r, c_vld_nxt;
  logic                  a_rdy, b_rdy, c_rdy;
  cell_stage_t           a_r, a_nxt, b_r, b_nxt;
  beat_t                 c_r, c_nxt;
  logic [BR_W-1:0]       base_sel, base;
  logic [2*BR_W-1:0]     hi_div, pm_div, lo_div;
  logic [BR_W:0]         dsum;
  logic [BR_W-1:0]       term;
  logic [WT_W+BR_W-1:0]  wt_full;

  assign c_rdy  = !c_vld_r || out_rdy;
  assign b_rdy  = !b_vld_r || c_rdy;
  assign a_rdy  = !a_vld_r || b_rdy;
  assign in_rdy = a_rdy;

  // stage a: fold previous product, upper dividend byte, path digit reduce
  always_comb begin
    base_sel = branching[in_beat.lvl[0]];
    base     = (base_sel == '0) ? BR_W'(1) : base_sel;
    hi_div   = div_steps('0, in_beat.rem[OPD_W-1 -: BR_W], base);
    pm_div   = div_steps('0, in_beat.path[0], base);

    a_nxt         = '0;
    a_nxt.bt      = in_beat;
    a_nxt.bt.id   = in_beat.id + ID_W'(in_beat.prod);
    a_nxt.bt.prod = '0;
    a_nxt.bt.rem  = {hi_div[BR_W-1:0], in_beat.rem[BR_W-1:0]};
    a_nxt.part    = hi_div[2*BR_W-1 -: BR_W];
    a_nxt.pmod    = pm_div[2*BR_W-1 -: BR_W];
    a_nxt.base    = base;
  end

  // stage b: lower dividend byte, remainder is this level's offset digit
  always_comb begin
    lo_div                  = div_steps(a_r.part, a_r.bt.rem[BR_W-1:0], a_r.base);
    b_nxt                   = a_r;
    b_nxt.bt.rem[BR_W-1:0]  = lo_div[BR_W-1:0];
    b_nxt.part              = lo_div[2*BR_W-1 -: BR_W];
  end

  // stage c: digit add without carry, weight the term, advance the weight
  always_comb begin
    dsum = {1'b0, b_r.pmod} + {1'b0, b_r.part};
    if (dsum >= {1'b0, b_r.base}) begin
      dsum = dsum - {1'b0, b_r.base};
    end
    term    = b_r.bt.nbr ? dsum[BR_W-1:0] : b_r.bt.path[0];
    wt_full = b_r.bt.wt * b_r.base;

    c_nxt = b_r.bt;
    for (int k = 0; k < NUM_LEVELS - 1; k++) begin
      c_nxt.path[k] = b_r.bt.path[k+1];
      c_nxt.lvl[k]  = b_r.bt.lvl[k+1];
    end
    c_nxt.path[NUM_LEVELS-1] = '0;
    c_nxt.lvl[NUM_LEVELS-1]  = '0;

    if (b_r.bt.cnt != '0) begin
      c_nxt.prod = term * b_r.bt.wt;
      c_nxt.wt   = wt_full[WT_W-1:0];
      c_nxt.cnt  = b_r.bt.cnt - CNT_W'(1);
    end else begin
      c_nxt.prod = '0;
    end
  end

  always_comb begin
    a_vld_nxt = a_rdy ? in_vld  : a_vld_r;
    b_vld_nxt = b_rdy ? a_vld_r : b_vld_r;
    c_vld_nxt = c_rdy ? b_vld_r : c_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      a_vld_r <= a_vld_nxt;
      b_vld_r <= b_vld_nxt;
      c_vld_r <= c_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_r <= a_nxt;
    end
    if (b_rdy) begin
      b_r <= b_nxt;
    end
    if (c_rdy) begin
      c_r <= c_nxt;
    end
  end

  assign out_vld  = c_vld_r;
  assign out_beat = c_r;

endmodule

>>> rtl/core/tree_rank_neighbour_ancestor.sv
// top level: config registers, front stage, chain of level cells, result register
// throughput: one beat per cycle, set by one front stage, three stages per level cell
// (four cells) and one result stage, each stage holding a beat when the next is full
// stall on the output fills the empty stages first, then backs up to in_stall
// reset (synchronous, rst_n low) empties the pipe and loads branching 2, sizes 1, 2, 4, 8
module tree_rank_neighbour_ancestor import trna_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_cmd,
  input  logic [RANK_W-1:0]      in_node_rank,
  input  logic [DEPTH_W-1:0]     in_node_depth,
  input  logic [BR_W-1:0]        in_path_digit_0,
  input  logic [BR_W-1:0]        in_path_digit_1,
  input  logic [BR_W-1:0]        in_path_digit_2,
  input  logic [BR_W-1:0]        in_path_digit_3,
  input  logic [OPD_W-1:0]       in_request_operand,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [RANK_W-1:0]      out_result_rank,
  output logic                   out_bad_request,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  br_arr_t            br_r, br_nxt;
  size_arr_t          size_r, size_nxt;
  br_arr_t            path_in;
  logic               prep_rdy;
  logic [NUM_LEVELS:0] chain_vld, chain_rdy;
  beat_t              chain_beat [NUM_LEVELS+1];
  logic               out_valid_r, out_valid_nxt, out_rdy;
  logic [RANK_W-1:0]  rank_r, rank_nxt;
  logic               bad_r, bad_nxt;
  logic [ID_W-1:0]    val, sat;

  // configuration writes
  always_comb begin
    br_nxt   = br_r;
    size_nxt = size_r;
    if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_BRANCHING_0: br_nxt[0]   = cfg_data[BR_W-1:0];
        CFG_BRANCHING_1: br_nxt[1]   = cfg_data[BR_W-1:0];
        CFG_BRANCHING_2: br_nxt[2]   = cfg_data[BR_W-1:0];
        CFG_BRANCHING_3: br_nxt[3]   = cfg_data[BR_W-1:0];
        CFG_LVL_SIZE_0:  size_nxt[0] = cfg_data[SIZE_W-1:0];
        CFG_LVL_SIZE_1:  size_nxt[1] = cfg_data[SIZE_W-1:0];
        CFG_LVL_SIZE_2:  size_nxt[2] = cfg_data[SIZE_W-1:0];
        CFG_LVL_SIZE_3:  size_nxt[3] = cfg_data[SIZE_W-1:0];
        default: begin
          br_nxt   = br_r;
          size_nxt = size_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_LEVELS; k++) begin
        br_r[k]   <= BR_W'(2);
        size_r[k] <= SIZE_W'(1) << k;
      end
    end else begin
      br_r   <= br_nxt;
      size_r <= size_nxt;
    end
  end

  assign path_in  = {in_path_digit_3, in_path_digit_2, in_path_digit_1, in_path_digit_0};
  assign in_stall = !prep_rdy;

  trna_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (in_valid),
    .in_rdy     (prep_rdy),
    .cmd        (in_cmd),
    .node_rank  (in_node_rank),
    .node_depth (in_node_depth),
    .path_in    (path_in),
    .operand    (in_request_operand),
    .lvl_size   (size_r),
    .out_vld    (chain_vld[0]),
    .out_beat   (chain_beat[0]),
    .out_rdy    (chain_rdy[0])
  );

  for (genvar c = 0; c < NUM_LEVELS; c++) begin : g_cell
    trna_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .branching (br_r),
      .in_vld    (chain_vld[c]),
      .in_beat   (chain_beat[c]),
      .in_rdy    (chain_rdy[c]),
      .out_vld   (chain_vld[c+1]),
      .out_beat  (chain_beat[c+1]),
      .out_rdy   (chain_rdy[c+1])
    );
  end

  // result stage: last product, level start, saturation
  assign out_rdy               = !out_valid_r || !out_stall;
  assign chain_rdy[NUM_LEVELS] = out_rdy;

  always_comb begin
    if (chain_beat[NUM_LEVELS].ovr) begin
      val = ID_W'(chain_beat[NUM_LEVELS].ovr_rank);
    end else begin
      val = chain_beat[NUM_LEVELS].id + ID_W'(chain_beat[NUM_LEVELS].prod)
          + ID_W'(chain_beat[NUM_LEVELS].start);
    end
    sat           = (val > RANK_MAX) ? RANK_MAX : val;
    rank_nxt      = sat[RANK_W-1:0];
    bad_nxt       = chain_beat[NUM_LEVELS].bad;
    out_valid_nxt = out_rdy ? chain_vld[NUM_LEVELS] : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_rdy) begin
      rank_r <= rank_nxt;
      bad_r  <= bad_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_rank = rank_r;
  assign out_bad_request = bad_r;

endmodule
